// File: hdl/gptt_pkg.sv
// Package for the guest page table translator.
// Holds table geometry, operation codes and entry attribute constants.
// No dependencies.
package gptt_pkg;

	localparam int TABLE_ENTRIES = 512;
	localparam int PAGE_SHIFT    = 12;
	localparam int ENTRY_W       = 64;
	localparam int GADDR_W       = 48;
	localparam int HADDR_W       = 64;
	localparam int SIZE_W        = 32;
	localparam int KIND_W        = 2;

	localparam logic [KIND_W-1:0] KIND_INIT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MAP    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

	// read, write, execute and write-back memory type
	localparam logic [PAGE_SHIFT-1:0] INIT_ATTR = 12'h037;

endpackage

// File: hdl/gptt_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// Read data holds while no read is issued. No dependencies.
module gptt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/guest_page_table_translate_top.sv
// Top level of the guest page table translator.
// Depends on gptt_pkg and gptt_ram (last-level table storage).
//
// Usage:
//   Input transactions arrive on s_tvalid/s_tready with the operation in
//   s_tuser and guest, host, size and flag fields in s_tdata. Only a lookup
//   produces an output transaction on m_tvalid/m_tready: the host address in
//   m_tdata and the fault flag in m_tuser.
//   A map writes its entry as it is accepted; a lookup does one registered
//   table read and then loads the output register. An init sweeps every
//   table entry, one RAM write per cycle; the single RAM write port sets
//   that rate. After reset the block runs a clearing pass over every entry
//   that zeroes the table; s_tready stays low until it ends. Upper levels
//   start absent, so every lookup faults until an init.
//   A stalled receiver holds the result in the output register; maps and
//   inits are still taken, and a following lookup waits for the register.
module guest_page_table_translate_top #(
	parameter int TABLE_ENTRIES = gptt_pkg::TABLE_ENTRIES
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// guest_addr[47:0], host_addr[111:48], size_bytes[143:112], map_flags[207:144]
	input  logic [207:0] s_tdata,
	// kind[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// translated_addr[63:0]
	output logic [63:0]  m_tdata,
	// fault[0]
	output logic         m_tuser
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int PS    = gptt_pkg::PAGE_SHIFT;
	localparam int EW    = gptt_pkg::ENTRY_W;
	localparam int FW    = EW - PS;
	localparam int GW    = gptt_pkg::GADDR_W;
	localparam int HI_W  = GW - PS - IDX_W;
	localparam int CNT_W = gptt_pkg::SIZE_W - PS;

	localparam logic [1:0] ST_SWEEP = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_LOOK  = 2'd2;

	logic [GW-1:0]                 guest;
	logic [gptt_pkg::HADDR_W-1:0]  host;
	logic [gptt_pkg::SIZE_W-1:0]   size;
	logic [EW-1:0]                 flags;

	assign guest = s_tdata[47:0];
	assign host  = s_tdata[111:48];
	assign size  = s_tdata[143:112];
	assign flags = s_tdata[207:144];

	logic [1:0]       state_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] start_q;
	logic [IDX_W:0]   pages_q;
	logic [FW-1:0]    hbase_q;
	logic             upper_q;
	logic             ok_q;
	logic [PS-1:0]    off_q;
	logic             out_valid_q;
	logic [EW-1:0]    out_data_q;
	logic             out_fault_q;

	logic             accept;
	logic [IDX_W-1:0] slot;
	logic [IDX_W-1:0] rel;
	logic [IDX_W:0]   pages_in;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [EW-1:0]    ram_wdata;
	logic [EW-1:0]    ram_rdata;
	logic             out_load;
	logic             hit;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign slot     = guest[PS +: IDX_W];
	assign rel      = idx_q - start_q;
	assign pages_in = (size[gptt_pkg::SIZE_W-1:PS] > CNT_W'(TABLE_ENTRIES))
		? (IDX_W+1)'(TABLE_ENTRIES) : size[PS +: IDX_W+1];
	assign out_load = (state_q == ST_LOOK) && (!out_valid_q || m_tready);
	assign hit      = ok_q && ram_rdata[0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot;
		ram_wdata = {host[EW-1:PS], {PS{1'b0}}} | flags;
		if (state_q == ST_SWEEP) begin
			ram_we    = 1'b1;
			ram_waddr = idx_q;
			if ({1'b0, rel} < pages_q) begin
				ram_wdata = {hbase_q + FW'(rel), gptt_pkg::INIT_ATTR};
			end else begin
				ram_wdata = '0;
			end
		end else if (accept && s_tuser == gptt_pkg::KIND_MAP) begin
			ram_we = 1'b1;
		end
	end

	gptt_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (accept && s_tuser == gptt_pkg::KIND_LOOKUP),
		.raddr(slot),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			idx_q   <= '0;
			start_q <= '0;
			pages_q <= '0;
			upper_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_SWEEP: begin
					idx_q <= idx_q + 1'b1;
					if (&idx_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && s_tuser == gptt_pkg::KIND_INIT) begin
						state_q <= ST_SWEEP;
						idx_q   <= '0;
						start_q <= slot;
						pages_q <= pages_in;
						upper_q <= 1'b1;
					end else if (accept && s_tuser == gptt_pkg::KIND_LOOKUP) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hbase_q <= host[EW-1:PS];
			ok_q    <= upper_q && (guest[GW-1 -: HI_W] == '0);
			off_q   <= guest[PS-1:0];
		end
		if (out_load) begin
			out_data_q  <= hit ? {ram_rdata[EW-1:PS], off_q} : '1;
			out_fault_q <= !hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_fault_q;

	a_lookup_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == gptt_pkg::KIND_LOOKUP) |=> state_q == ST_LOOK)
		else $error("lookup did not enter read state");

	a_fault_ones: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (&m_tdata))
		else $error("faulted result not all ones");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |-> !ram_we)
		else $error("table written during lookup read");

	a_upper_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		upper_q |=> upper_q)
		else $error("upper levels lost presence");

	a_init_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == gptt_pkg::KIND_INIT) |=> (state_q == ST_SWEEP && idx_q == '0))
		else $error("init did not start sweep at entry zero");

endmodule
